/* src/dmb_pkg.sv */
package dmb_pkg;

  // Defaults for the top level parameters
  localparam int MAX_COLS_DEF    = 1024;
  localparam int BLUR_RADIUS_DEF = 2;

  // Image limits and register widths
  localparam int MAX_ROWS     = 4096;
  localparam int WIDTH_W      = 11;
  localparam int HEIGHT_W     = 13;
  localparam int ROW_W        = 12;
  localparam int COL_OUT_W    = 10;
  localparam int CH_W         = 8;
  localparam int PIX_W        = 4 * CH_W;
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = HEIGHT_W;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT = 2'd1;

  // Item kinds
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  typedef struct packed {
    logic            func;
    logic [CH_W-1:0] in_blue;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_alpha;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]      out_blue;
    logic [CH_W-1:0]      out_green;
    logic [CH_W-1:0]      out_red;
    logic [CH_W-1:0]      out_alpha;
    logic [ROW_W-1:0]     out_row;
    logic [COL_OUT_W-1:0] out_col;
    logic                 frame_last;
  } out_item_t;

endpackage

/* src/diagonal_motion_blur_filter_top.sv */
// Channel  Handshake              Payload                 Direction
// -------  ---------------------  ----------------------  ---------
// in       in_valid / in_ready    in_data  (in_item_t)    into block
// out      out_valid / out_ready  out_data (out_item_t)   out of block
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data     into block
//
// One item per cycle while in_ready is high; a result passes the line store registered read,
// the tap sum register and the reciprocal multiply into the output register.
// The diagonal taps come from one line store copy per tap, all written alike.
// Reset clears pointers, pending count and positions and loads 640 x 480;
// the line store is not cleared and needs no clearing pass.
// With out_ready low the three result stages fill, then in_ready drops.
module diagonal_motion_blur_filter_top #(
  parameter int MAX_COLS    = dmb_pkg::MAX_COLS_DEF,
  parameter int BLUR_RADIUS = dmb_pkg::BLUR_RADIUS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  dmb_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output dmb_pkg::out_item_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dmb_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [dmb_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import dmb_pkg::*;

  localparam int TAPS       = 2 * BLUR_RADIUS + 1;
  localparam int SD         = 2 * BLUR_RADIUS * (MAX_COLS + 1) + 1;
  localparam int PTR_W      = $clog2(SD);
  localparam int COL_W      = (MAX_COLS > 2047) ? WIDTH_W : $clog2(MAX_COLS);
  localparam int SUM_W      = $clog2(255 * TAPS + 1);
  localparam int DIV_SHIFT  = 16;
  localparam int RECIP      = (2 ** DIV_SHIFT + TAPS - 1) / TAPS;
  localparam int PROD_W     = SUM_W + DIV_SHIFT;
  localparam int W_RST_EFF  = (WIDTH_RESET > MAX_COLS) ? MAX_COLS : WIDTH_RESET;

  // Frame size registers and precomputed diagonal offsets k*(w+1)
  logic [WIDTH_W-1:0]  width_eff;
  logic [HEIGHT_W-1:0] height_eff;
  logic [PTR_W-1:0]    tap_off [BLUR_RADIUS];
  logic [WIDTH_W-1:0]  w_clamp;
  logic [HEIGHT_W-1:0] h_clamp;
  logic [PTR_W-1:0]    tap_off_next [BLUR_RADIUS];

  // Stream state
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] base;
  logic [PTR_W-1:0] pending;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;

  // Accept-cycle decode
  logic               acc;
  logic               is_pix;
  logic               emit;
  logic [PTR_W:0]     pend_post;
  logic               interior;
  logic               last;
  logic [PTR_W-1:0]   rd_addr [TAPS];
  logic               tap_use [TAPS];
  logic               tap_hit [TAPS];
  logic [PIX_W-1:0]   wr_pix;
  logic [PIX_W-1:0]   rd_data [TAPS];

  // Result pipeline
  logic               rdy1, rdy2, rdy3;
  logic               v1, v2;
  logic               s1_use [TAPS];
  logic               s1_hit [TAPS];
  logic [PIX_W-1:0]   s1_fwd;
  logic [ROW_W-1:0]   s1_row;
  logic [COL_W-1:0]   s1_col;
  logic               s1_last;
  logic [SUM_W-1:0]   sum_next [4];
  logic [SUM_W-1:0]   s2_sum [4];
  logic [ROW_W-1:0]   s2_row;
  logic [COL_W-1:0]   s2_col;
  logic               s2_last;
  logic [CH_W-1:0]    quot [4];

  assign cfg_ready = 1'b1;

  // Clamp written sizes and derive tap offsets
  always_comb begin
    if (cfg_data[WIDTH_W-1:0] == '0) begin
      w_clamp = WIDTH_W'(1);
    end else if (int'(cfg_data[WIDTH_W-1:0]) > MAX_COLS) begin
      w_clamp = WIDTH_W'(MAX_COLS);
    end else begin
      w_clamp = cfg_data[WIDTH_W-1:0];
    end
    if (cfg_data == '0) begin
      h_clamp = HEIGHT_W'(1);
    end else if (int'(cfg_data) > MAX_ROWS) begin
      h_clamp = HEIGHT_W'(MAX_ROWS);
    end else begin
      h_clamp = cfg_data;
    end
    for (int i = 0; i < BLUR_RADIUS; i++) begin
      tap_off_next[i] = PTR_W'((i + 1) * (int'(w_clamp) + 1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff  <= WIDTH_W'(W_RST_EFF);
      height_eff <= HEIGHT_W'(HEIGHT_RESET);
      for (int i = 0; i < BLUR_RADIUS; i++) begin
        tap_off[i] <= PTR_W'((i + 1) * (W_RST_EFF + 1));
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WIDTH: begin
          width_eff <= w_clamp;
          tap_off   <= tap_off_next;
        end
        REG_HEIGHT: begin
          height_eff <= h_clamp;
        end
        default: ;
      endcase
    end
  end

  // Decode the presented item
  assign acc       = in_valid && in_ready;
  assign is_pix    = (in_data.func == FUNC_PIXEL);
  assign emit      = is_pix ? (pending >= tap_off[BLUR_RADIUS-1]) : (pending != '0);
  assign pend_post = {1'b0, pending} + (PTR_W+1)'(is_pix);
  assign wr_pix    = {in_data.in_alpha, in_data.in_red, in_data.in_green, in_data.in_blue};

  // Position of the next output pixel
  always_comb begin
    interior = (out_row >= ROW_W'(BLUR_RADIUS))
            && (HEIGHT_W'(out_row) + HEIGHT_W'(BLUR_RADIUS) < height_eff)
            && (out_col >= COL_W'(BLUR_RADIUS))
            && ((WIDTH_W+1)'(out_col) + (WIDTH_W+1)'(BLUR_RADIUS)
                < (WIDTH_W+1)'(width_eff));
    last = (HEIGHT_W'(out_row) + HEIGHT_W'(1) == height_eff)
        && ((WIDTH_W+1)'(out_col) + (WIDTH_W+1)'(1) == (WIDTH_W+1)'(width_eff));
  end

  // Tap addresses around the center entry, wrapped into the store
  always_comb begin
    for (int j = 0; j < TAPS; j++) begin
      rd_addr[j] = base;
      tap_use[j] = interior;
      if (j > BLUR_RADIUS) begin
        if (int'(base) + int'(tap_off[j-BLUR_RADIUS-1]) >= SD) begin
          rd_addr[j] = PTR_W'(int'(base) + int'(tap_off[j-BLUR_RADIUS-1]) - SD);
        end else begin
          rd_addr[j] = PTR_W'(int'(base) + int'(tap_off[j-BLUR_RADIUS-1]));
        end
        tap_use[j] = interior && ((PTR_W+1)'(tap_off[j-BLUR_RADIUS-1]) < pend_post);
      end else if (j < BLUR_RADIUS) begin
        if (base < tap_off[BLUR_RADIUS-1-j]) begin
          rd_addr[j] = PTR_W'(int'(base) + SD - int'(tap_off[BLUR_RADIUS-1-j]));
        end else begin
          rd_addr[j] = base - tap_off[BLUR_RADIUS-1-j];
        end
      end
      tap_hit[j] = is_pix && (rd_addr[j] == wr_ptr);
    end
  end

  // One store copy per tap, all written with the incoming pixel
  for (genvar g = 0; g < TAPS; g++) begin : g_store
    dmb_ram #(
      .WIDTH (PIX_W),
      .DEPTH (SD)
    ) u_store (
      .clk     (clk),
      .wr_en   (acc && is_pix),
      .wr_addr (wr_ptr),
      .wr_data (wr_pix),
      .rd_en   (acc && emit),
      .rd_addr (rd_addr[g]),
      .rd_data (rd_data[g])
    );
  end

  // Advance pointers, pending count and output position
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      base    <= '0;
      pending <= '0;
      out_row <= '0;
      out_col <= '0;
    end else if (acc) begin
      if (is_pix) begin
        wr_ptr <= (int'(wr_ptr) == SD - 1) ? '0 : wr_ptr + PTR_W'(1);
      end
      pending <= PTR_W'(pend_post - (PTR_W+1)'(emit));
      if (emit) begin
        base <= (int'(base) == SD - 1) ? '0 : base + PTR_W'(1);
        if ((WIDTH_W+1)'(out_col) + (WIDTH_W+1)'(1) >= (WIDTH_W+1)'(width_eff)) begin
          out_col <= '0;
          if (HEIGHT_W'(out_row) + HEIGHT_W'(1) >= height_eff) begin
            out_row <= '0;
          end else begin
            out_row <= out_row + ROW_W'(1);
          end
        end else begin
          out_col <= out_col + COL_W'(1);
        end
      end
    end
  end

  // Stage flow
  assign rdy3     = !out_valid || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= acc && emit;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        out_valid <= v2;
      end
    end
  end

  // Stage 1: hold tap controls next to the store read
  always_ff @(posedge clk) begin
    if (acc && emit) begin
      s1_use  <= tap_use;
      s1_hit  <= tap_hit;
      s1_fwd  <= wr_pix;
      s1_row  <= out_row;
      s1_col  <= out_col;
      s1_last <= last;
    end
  end

  // Sum the taps per channel, forwarding the pixel written with the read
  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      sum_next[ch] = '0;
      for (int j = 0; j < TAPS; j++) begin
        if (s1_use[j]) begin
          if (s1_hit[j]) begin
            sum_next[ch] = sum_next[ch] + SUM_W'(s1_fwd[ch*CH_W +: CH_W]);
          end else begin
            sum_next[ch] = sum_next[ch] + SUM_W'(rd_data[j][ch*CH_W +: CH_W]);
          end
        end
      end
    end
  end

  // Stage 2: channel sums
  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      s2_sum  <= sum_next;
      s2_row  <= s1_row;
      s2_col  <= s1_col;
      s2_last <= s1_last;
    end
  end

  // Divide by the tap count through a reciprocal multiply
  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      quot[ch] = CH_W'((PROD_W'(s2_sum[ch]) * PROD_W'(RECIP)) >> DIV_SHIFT);
    end
  end

  // Stage 3: output register
  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      out_data.out_blue   <= quot[0];
      out_data.out_green  <= quot[1];
      out_data.out_red    <= quot[2];
      out_data.out_alpha  <= quot[3];
      out_data.out_row    <= s2_row;
      out_data.out_col    <= COL_OUT_W'(s2_col);
      out_data.frame_last <= s2_last;
    end
  end

  // Center read pointer trails the write pointer by the pending count
  a_base_tracks: assert property (@(posedge clk) disable iff (rst)
    (wr_ptr >= base) ? (wr_ptr - base == pending)
                     : (int'(wr_ptr) + SD - int'(base) == int'(pending)))
    else $error("center pointer out of step with pending count");

  // An emitting item always enters the result pipeline
  a_emit_enters: assert property (@(posedge clk) disable iff (rst)
    acc && emit |=> v1)
    else $error("emitted item did not reach stage 1");

  // A blocked stage 1 keeps its item
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    v1 && !rdy2 |=> v1 && $stable(s1_row) && $stable(s1_col))
    else $error("stage 1 lost its item under stall");

endmodule

/* src/dmb_ram.sv */
module dmb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and registered read that returns the old entry on a collision
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* verif/tb_diagonal_motion_blur_filter_top.sv */
module tb_diagonal_motion_blur_filter_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dmb_pkg::*;

  localparam int RADIUS        = BLUR_RADIUS_DEF;
  localparam int COLS_MAX      = MAX_COLS_DEF;
  localparam int TAP_COUNT     = 2 * RADIUS + 1;
  localparam int HIST_DEPTH    = 2 * RADIUS * (COLS_MAX + 1) + 1;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data  = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  diagonal_motion_blur_filter_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Blur predictor state: pixel history, raster positions, size registers
  logic [PIX_W-1:0]    pix_hist [HIST_DEPTH];
  int                  hist_wr;
  int                  awaiting_blur;
  int                  src_row, src_col;
  int                  res_row, res_col;
  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  out_item_t           blurred_q [$];

  int errors;
  int gap_odds;
  int stall_left;
  out_item_t got_pix;
  out_item_t want_pix;

  function automatic int cols_in_use();
    if (width_reg == 0) return 1;
    if (width_reg > COLS_MAX) return COLS_MAX;
    return width_reg;
  endfunction

  function automatic int rows_in_use();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_ROWS) return MAX_ROWS;
    return height_reg;
  endfunction

  function automatic void step_raster(inout int row, inout int col);
    if (col + 1 >= cols_in_use()) begin
      col = 0;
      row = (row + 1 >= rows_in_use()) ? 0 : row + 1;
    end else begin
      col = col + 1;
    end
  endfunction

  function automatic logic [CH_W-1:0] chan_avg(int total);
    int q;
    q = total / TAP_COUNT;
    return q[CH_W-1:0];
  endfunction

  function automatic void reset_model();
    foreach (pix_hist[i]) pix_hist[i] = '0;
    hist_wr       = 0;
    awaiting_blur = 0;
    src_row       = 0;
    src_col       = 0;
    res_row       = 0;
    res_col       = 0;
    width_reg     = WIDTH_W'(WIDTH_RESET);
    height_reg    = HEIGHT_W'(HEIGHT_RESET);
  endfunction

  // Blur the oldest unanswered pixel and queue it as the next expected result
  function automatic void predict_output();
    int cols, rows, d0, d;
    int sum [4];
    logic [PIX_W-1:0] px;
    out_item_t pix;
    cols = cols_in_use();
    rows = rows_in_use();
    for (int ch = 0; ch < 4; ch++) sum[ch] = 0;
    if (res_row >= RADIUS && res_row + RADIUS < rows &&
        res_col >= RADIUS && res_col + RADIUS < cols) begin
      d0 = awaiting_blur - 1;
      // Taps below the newest pixel have not arrived yet and count as zero
      for (int k = -RADIUS; k <= RADIUS; k++) begin
        d = d0 - k * (cols + 1);
        if (d >= 0 && d < HIST_DEPTH) begin
          px = pix_hist[(hist_wr + 2 * HIST_DEPTH - 1 - d) % HIST_DEPTH];
          for (int ch = 0; ch < 4; ch++) sum[ch] += px[CH_W*ch +: CH_W];
        end
      end
    end
    pix.out_blue   = chan_avg(sum[0]);
    pix.out_green  = chan_avg(sum[1]);
    pix.out_red    = chan_avg(sum[2]);
    pix.out_alpha  = chan_avg(sum[3]);
    pix.out_row    = res_row[ROW_W-1:0];
    pix.out_col    = res_col[COL_OUT_W-1:0];
    pix.frame_last = (res_row + 1 == rows && res_col + 1 == cols);
    blurred_q.push_back(pix);
    step_raster(res_row, res_col);
    awaiting_blur--;
  endfunction

  function automatic void absorb_item(in_item_t it);
    if (it.func == FUNC_FLUSH) begin
      if (awaiting_blur > 0) predict_output();
      return;
    end
    pix_hist[hist_wr] = {it.in_alpha, it.in_red, it.in_green, it.in_blue};
    hist_wr = (hist_wr + 1) % HIST_DEPTH;
    step_raster(src_row, src_col);
    awaiting_blur++;
    if (awaiting_blur > RADIUS * (cols_in_use() + 1)) predict_output();
  endfunction

  function automatic logic [CH_W-1:0] rand_channel();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return r[CH_W-1:0];
    endcase
  endfunction

  function automatic in_item_t pixel_item();
    in_item_t it;
    it.func     = FUNC_PIXEL;
    it.in_blue  = rand_channel();
    it.in_green = rand_channel();
    it.in_red   = rand_channel();
    it.in_alpha = rand_channel();
    return it;
  endfunction

  function automatic in_item_t flush_item();
    in_item_t it;
    it      = pixel_item();
    it.func = FUNC_FLUSH;
    return it;
  endfunction

  // Offer one item, optionally after a random gap, and hold it until accepted
  task automatic send_item(in_item_t it);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    absorb_item(it);
  endtask

  task automatic send_pixels(int n);
    repeat (n) send_item(pixel_item());
  endtask

  task automatic flush_all();
    while (awaiting_blur > 0) send_item(flush_item());
  endtask

  task automatic finish_frame();
    while (src_row != 0 || src_col != 0) send_item(pixel_item());
    flush_all();
  endtask

  // Hold the input until every expected result is out, then let the pipe settle
  task automatic wait_drain();
    int spin;
    in_valid <= 1'b0;
    spin = 0;
    while (blurred_q.size() != 0 && spin < DRAIN_LIMIT) begin
      @(posedge clk);
      spin++;
    end
    if (blurred_q.size() != 0) begin
      $error("%0d blurred pixels never came out", blurred_q.size());
      errors++;
      blurred_q.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both size registers while the block is idle
  task automatic set_size(int cols, int rows);
    logic [CFG_DATA_W-1:0] cols_v, rows_v;
    cols_v = cols[CFG_DATA_W-1:0];
    rows_v = rows[CFG_DATA_W-1:0];
    wait_drain();
    cfg_valid <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_data  <= cols_v;
    do @(posedge clk); while (!cfg_ready);
    width_reg = cols_v[WIDTH_W-1:0];
    cfg_index <= REG_HEIGHT;
    cfg_data  <= rows_v;
    do @(posedge clk); while (!cfg_ready);
    height_reg = rows_v;
    cfg_valid <= 1'b0;
  endtask

  // 5x5 frame: full-scale and floor-rounded sums on the one interior pixel
  task automatic test_diagonal_sum();
    in_item_t it;
    int v;
    gap_odds = 4;
    set_size(5, 5);
    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 5; c++) begin
        it = pixel_item();
        if (r == c) begin
          v           = r + 1;
          it.in_blue  = 8'hFF;
          it.in_green = 8'h00;
          it.in_red   = v[CH_W-1:0];
          it.in_alpha = (r == 0) ? 8'hFF : 8'hFE;
        end
        send_item(it);
      end
    end
    flush_all();
    // Nothing pending: this flush must give no result
    send_item(flush_item());
  endtask

  // Flush before the lower taps arrive, then complete the frame
  task automatic test_early_flush();
    gap_odds = 6;
    set_size(7, 6);
    send_pixels(17);
    flush_all();
    send_item(flush_item());
    finish_frame();
  endtask

  // Clamped sizes, the start of an over-wide frame and size changes mid-frame
  task automatic test_size_limits();
    gap_odds = 10;
    set_size(0, 0);
    send_pixels(10);
    flush_all();
    set_size(2047, 5);
    send_pixels(40);
    flush_all();
    set_size(7, 8191);
    send_pixels(60);
    flush_all();
    set_size(7, 6);
    send_pixels(40);
    flush_all();
    set_size(10, 6);
    finish_frame();
  endtask

  // Frames back to back with no flush between, paused once until caught up
  task automatic test_back_to_back();
    gap_odds = 0;
    set_size(6, 5);
    send_pixels(45);
    wait_drain();
    send_pixels(45);
    flush_all();
  endtask

  // Random sizes and content; mostly whole frames, some stray flushes and cut tails
  task automatic test_random_frames(int budget, bit calm);
    int done, cols, rows, frames;
    done = 0;
    while (done < budget) begin
      cols = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 12);
      rows = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 9);
      set_size(cols, rows);
      if (calm) begin
        gap_odds = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: gap_odds = 0;
          1: gap_odds = 3;
          default: gap_odds = 12;
        endcase
      end
      frames = $urandom_range(1, 3);
      repeat (frames * cols_in_use() * rows_in_use()) begin
        send_item(pixel_item());
        done++;
        case ($urandom_range(0, 59))
          0: send_item(flush_item());
          1: wait_drain();
          default: ;
        endcase
      end
      // Leave a broken partial frame now and then
      if ($urandom_range(0, 3) == 0) begin
        send_pixels($urandom_range(1, cols_in_use() * rows_in_use()));
        done++;
      end
      flush_all();
    end
  endtask

  // Receiver: random stall bursts, no new burst starting while gap_odds is zero
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      stall_left = $urandom_range(0, 8);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic void check_field(string name, int want_v, int got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      errors++;
    end
  endfunction

  // Compare each accepted result with the oldest expected blurred pixel
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_pix = out_data;
      if (blurred_q.size() == 0) begin
        $error("result at row %0d col %0d with none expected", got_pix.out_row,
               got_pix.out_col);
        errors++;
      end else begin
        want_pix = blurred_q.pop_front();
        check_field("out_blue", want_pix.out_blue, got_pix.out_blue);
        check_field("out_green", want_pix.out_green, got_pix.out_green);
        check_field("out_red", want_pix.out_red, got_pix.out_red);
        check_field("out_alpha", want_pix.out_alpha, got_pix.out_alpha);
        check_field("out_row", want_pix.out_row, got_pix.out_row);
        check_field("out_col", want_pix.out_col, got_pix.out_col);
        check_field("frame_last", want_pix.frame_last, got_pix.frame_last);
      end
    end
  end

  initial begin
    errors     = 0;
    gap_odds   = 0;
    stall_left = 0;
    reset_model();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_diagonal_sum();
    test_early_flush();
    test_size_limits();
    test_back_to_back();
    test_random_frames(450, 1'b0);
    test_random_frames(100, 1'b1);
    wait_drain();
    if (errors == 0) begin
      $display("diagonal_motion_blur_filter_top test passed");
    end else begin
      $display("diagonal_motion_blur_filter_top test failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #10_000_000;
    $display("diagonal_motion_blur_filter_top test failed");
    $finish;
  end

endmodule

/* sim.f */
src/dmb_pkg.sv
src/dmb_ram.sv
src/diagonal_motion_blur_filter_top.sv
verif/tb_diagonal_motion_blur_filter_top.sv
